### src/ddo_pkg.sv
package ddo_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int FRAC_BITS = 16;
	localparam int DIV_STEPS = 54;
	localparam int CNT_W = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [20:0] DIAM_RESET = 21'd6423;
	localparam logic [20:0] BASE_RESET = 21'd15073;
	localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
	localparam logic [63:0] RAD_TO_BAM = 64'd2734261102;

	localparam logic [CFG_IDX_W-1:0] REG_DIAMETER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BASE = CFG_IDX_W'(1);

	localparam logic [3:0] OP_NOP = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_PREP = 4'd3;
	localparam logic [3:0] OP_ITER = 4'd4;
	localparam logic [3:0] OP_DFIN = 4'd5;
	localparam logic [3:0] OP_PMUL = 4'd6;
	localparam logic [3:0] OP_PADD = 4'd7;
	localparam logic [3:0] OP_HUPD = 4'd8;
	localparam logic [3:0] OP_QINIT = 4'd9;
	localparam logic [3:0] OP_QITER = 4'd10;
	localparam logic [3:0] OP_OUT = 4'd11;

	typedef struct packed {
		logic [3:0] op;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

### src/ddo_ctrl.sv
module ddo_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output ddo_pkg::cmd_t cmd
);
	import ddo_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL = 4'd1;
	localparam logic [3:0] S_PREP = 4'd2;
	localparam logic [3:0] S_ITER = 4'd3;
	localparam logic [3:0] S_DFIN = 4'd4;
	localparam logic [3:0] S_PMUL = 4'd5;
	localparam logic [3:0] S_PADD = 4'd6;
	localparam logic [3:0] S_HUPD = 4'd7;
	localparam logic [3:0] S_QINIT = 4'd8;
	localparam logic [3:0] S_QITER = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0] state_q;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.cnt = cnt_q;
		case (state_q)
			S_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NOP;
			S_MUL: cmd.op = OP_MUL;
			S_PREP: cmd.op = OP_PREP;
			S_ITER: cmd.op = OP_ITER;
			S_DFIN: cmd.op = OP_DFIN;
			S_PMUL: cmd.op = OP_PMUL;
			S_PADD: cmd.op = OP_PADD;
			S_HUPD: cmd.op = OP_HUPD;
			S_QINIT: cmd.op = OP_QINIT;
			S_QITER: cmd.op = OP_QITER;
			S_DONE: cmd.op = out_free ? OP_OUT : OP_NOP;
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			cnt_q <= cnt_q + CNT_W'(1);
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == CNT_W'(3)) begin
						state_q <= S_PREP;
						cnt_q <= '0;
					end
				end
				S_PREP: begin
					state_q <= S_ITER;
					cnt_q <= '0;
				end
				S_ITER: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_DFIN;
						cnt_q <= '0;
					end
				end
				S_DFIN: begin
					state_q <= S_PMUL;
					cnt_q <= '0;
				end
				S_PMUL: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_PADD;
						cnt_q <= '0;
					end
				end
				S_PADD: state_q <= S_HUPD;
				S_HUPD: state_q <= S_QINIT;
				S_QINIT: begin
					state_q <= S_QITER;
					cnt_q <= '0;
				end
				S_QITER: begin
					if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
						state_q <= S_DONE;
						cnt_q <= '0;
					end
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### src/ddo_dp.sv
module ddo_dp (
	input  logic clk,
	input  logic arst_n,
	input  ddo_pkg::cmd_t cmd,
	input  logic cfg_we,
	input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [20:0] cfg_data,
	input  logic signed [31:0] right_velocity,
	input  logic signed [31:0] left_velocity,
	input  logic signed [31:0] right_displacement,
	input  logic signed [31:0] left_displacement,
	input  logic signed [31:0] left_ticks,
	input  logic signed [31:0] right_ticks,
	output logic signed [47:0] pos_x,
	output logic signed [47:0] pos_y,
	output logic signed [31:0] heading,
	output logic signed [31:0] quat_z,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] linear_velocity,
	output logic signed [31:0] angular_velocity,
	output logic signed [31:0] left_ticks_out,
	output logic signed [31:0] right_ticks_out
);
	import ddo_pkg::*;

	localparam logic signed [55:0] RND_V = 56'sd1 <<< (FRAC_BITS + 1);
	localparam logic signed [63:0] RND_P = 64'sd1 <<< 29;
	localparam logic [63:0] RND_B = 64'd1 << (FRAC_BITS + 1);

	logic [20:0] diam_q, base_q;
	logic signed [47:0] posx_q, posy_q;
	logic signed [31:0] head_q;

	logic signed [31:0] vr_q, vl_q, dr_q, dl_q, lt_q, rt_q;
	logic signed [54:0] prod_q [4];
	logic signed [31:0] lin_q, step_q, angv_q, dth_q;
	logic neg_a_q, neg_t_q;
	logic [53:0] dq_a_q, dq_t_q;
	logic [21:0] rem_a_q, rem_t_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic signed [31:0] c_q, s_q;
	logic signed [63:0] px_q, py_q;
	logic [63:0] bam_q;

	logic signed [32:0] opnd;
	logic signed [54:0] prod;
	logic [20:0] bnz;
	logic [21:0] b2;
	logic [53:0] mag_a, mag_t;
	logic [22:0] tr_a, tr_t;
	logic ge_a, ge_t;
	logic signed [33:0] xs, ys;
	logic [31:0] atn;
	logic signed [31:0] mopnd;
	logic signed [63:0] mprod;
	logic signed [31:0] half;
	logic [31:0] dmag;
	logic [63:0] bsum;
	logic [31:0] dbam;

	function automatic logic signed [31:0] sat_rnd(input logic signed [54:0] p);
		logic signed [55:0] t;
		t = ($signed({p[54], p}) + RND_V) >>> (FRAC_BITS + 2);
		if (t > 56'sd2147483647) return 32'sh7fffffff;
		if (t < -56'sd2147483648) return 32'sh80000000;
		return t[31:0];
	endfunction

	function automatic logic signed [31:0] sat_q(input logic [53:0] q, input logic neg);
		if (!neg) begin
			if (q > 54'd2147483647) return 32'sh7fffffff;
			return q[31:0];
		end
		if (q > 54'd2147483648) return 32'sh80000000;
		return 32'(-q[31:0]);
	endfunction

	function automatic logic signed [31:0] clamp30(input logic signed [33:0] v);
		if (v > 34'sd1073741824) return 32'sd1073741824;
		if (v < -34'sd1073741824) return -32'sd1073741824;
		return v[31:0];
	endfunction

	function automatic logic signed [47:0] pos_add(input logic signed [47:0] p,
		input logic signed [63:0] m);
		logic signed [63:0] r;
		logic signed [49:0] s;
		r = (m + RND_P) >>> 30;
		s = {{2{p[47]}}, p} + r[49:0];
		if (s > 50'sh07fffffffffff) return 48'sh7fffffffffff;
		if (s < -50'sh0800000000000) return 48'sh800000000000;
		return s[47:0];
	endfunction

	function automatic logic [101:0] cordic_init(input logic signed [31:0] a);
		logic signed [33:0] x, z;
		x = GAIN_INV;
		z = {{2{a[31]}}, a};
		if (z > 34'sd1073741824 || z < -34'sd1073741824) begin
			x = -GAIN_INV;
			z = {{2{~a[31]}}, ~a[31], a[30:0]};
		end
		return {x, 34'sd0, z};
	endfunction

	assign bnz = (base_q == '0) ? 21'd1 : base_q;
	assign b2 = {bnz, 1'b0};

	always_comb begin
		case (cmd.cnt[1:0])
			2'd0: opnd = {vr_q[31], vr_q} + {vl_q[31], vl_q};
			2'd1: opnd = {vr_q[31], vr_q} - {vl_q[31], vl_q};
			2'd2: opnd = {dr_q[31], dr_q} + {dl_q[31], dl_q};
			default: opnd = {dr_q[31], dr_q} - {dl_q[31], dl_q};
		endcase
	end
	assign prod = $signed({1'b0, diam_q}) * opnd;

	assign mag_a = prod_q[1][54] ? 54'(-prod_q[1]) : prod_q[1][53:0];
	assign mag_t = prod_q[3][54] ? 54'(-prod_q[3]) : prod_q[3][53:0];

	assign tr_a = {rem_a_q, dq_a_q[53]};
	assign tr_t = {rem_t_q, dq_t_q[53]};
	assign ge_a = tr_a >= 23'(b2);
	assign ge_t = tr_t >= 23'(b2);

	assign xs = cx_q >>> cmd.cnt[4:0];
	assign ys = cy_q >>> cmd.cnt[4:0];
	assign atn = atan_lut(cmd.cnt[4:0]);

	assign mopnd = cmd.cnt[0] ? s_q : c_q;
	assign mprod = step_q * mopnd;

	assign half = head_q >>> 1;
	assign dmag = dth_q[31] ? 32'(-dth_q) : dth_q;
	assign bsum = bam_q + RND_B;
	assign dbam = bsum[FRAC_BITS + 33 : FRAC_BITS + 2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diam_q <= DIAM_RESET;
			base_q <= BASE_RESET;
			posx_q <= '0;
			posy_q <= '0;
			head_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_DIAMETER) diam_q <= cfg_data;
			if (cfg_we && cfg_index == REG_BASE) base_q <= cfg_data;
			if (cmd.op == OP_PADD) begin
				posx_q <= pos_add(posx_q, px_q);
				posy_q <= pos_add(posy_q, py_q);
			end
			if (cmd.op == OP_HUPD) begin
				head_q <= head_q + (neg_t_q ? 32'(-dbam) : dbam);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				vr_q <= right_velocity;
				vl_q <= left_velocity;
				dr_q <= right_displacement;
				dl_q <= left_displacement;
				lt_q <= left_ticks;
				rt_q <= right_ticks;
			end
			OP_MUL: prod_q[cmd.cnt[1:0]] <= prod;
			OP_PREP: begin
				lin_q <= sat_rnd(prod_q[0]);
				step_q <= sat_rnd(prod_q[2]);
				neg_a_q <= prod_q[1][54];
				neg_t_q <= prod_q[3][54];
				dq_a_q <= mag_a + 54'(bnz);
				dq_t_q <= mag_t + 54'(bnz);
				rem_a_q <= '0;
				rem_t_q <= '0;
				{cx_q, cy_q, cz_q} <= cordic_init(head_q);
			end
			OP_ITER, OP_QITER: begin
				if (cmd.op == OP_ITER) begin
					rem_a_q <= ge_a ? 22'(tr_a - 23'(b2)) : tr_a[21:0];
					rem_t_q <= ge_t ? 22'(tr_t - 23'(b2)) : tr_t[21:0];
					dq_a_q <= {dq_a_q[52:0], ge_a};
					dq_t_q <= {dq_t_q[52:0], ge_t};
				end
				if (cmd.cnt < CNT_W'(CORDIC_STEPS)) begin
					if (!cz_q[33]) begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - $signed({2'b00, atn});
					end else begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + $signed({2'b00, atn});
					end
				end
			end
			OP_DFIN: begin
				angv_q <= sat_q(dq_a_q, neg_a_q);
				dth_q <= sat_q(dq_t_q, neg_t_q);
				c_q <= clamp30(cx_q);
				s_q <= clamp30(cy_q);
			end
			OP_PMUL: begin
				if (cmd.cnt[0]) py_q <= mprod;
				else px_q <= mprod;
			end
			OP_PADD: bam_q <= {32'd0, dmag} * RAD_TO_BAM;
			OP_QINIT: {cx_q, cy_q, cz_q} <= cordic_init(half);
			OP_OUT: begin
				pos_x <= posx_q;
				pos_y <= posy_q;
				heading <= head_q;
				quat_z <= clamp30(cy_q);
				quat_w <= clamp30(cx_q);
				linear_velocity <= lin_q;
				angular_velocity <= angv_q;
				left_ticks_out <= lt_q;
				right_ticks_out <= rt_q;
			end
			default: ;
		endcase
	end

endmodule

### src/diff_drive_odometry.sv
// an input transaction is taken only while idle; its result is valid after
// the 54-step shared-clock divider pair, the position and heading update and
// the 24-step cordic for the quaternion
// an input transaction is taken again while a finished result still waits
// reset: position and heading cleared, wheel diameter 6423, wheel base 15073
module diff_drive_odometry (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [20:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] right_velocity,
	input  logic signed [31:0] left_velocity,
	input  logic signed [31:0] right_displacement,
	input  logic signed [31:0] left_displacement,
	input  logic signed [31:0] left_ticks,
	input  logic signed [31:0] right_ticks,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [47:0] pos_x,
	output logic signed [47:0] pos_y,
	output logic signed [31:0] heading,
	output logic signed [31:0] quat_z,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] linear_velocity,
	output logic signed [31:0] angular_velocity,
	output logic signed [31:0] left_ticks_out,
	output logic signed [31:0] right_ticks_out
);
	import ddo_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	ddo_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd)
	);

	ddo_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg_we(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.right_velocity(right_velocity),
		.left_velocity(left_velocity),
		.right_displacement(right_displacement),
		.left_displacement(left_displacement),
		.left_ticks(left_ticks),
		.right_ticks(right_ticks),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.heading(heading),
		.quat_z(quat_z),
		.quat_w(quat_w),
		.linear_velocity(linear_velocity),
		.angular_velocity(angular_velocity),
		.left_ticks_out(left_ticks_out),
		.right_ticks_out(right_ticks_out)
	);

endmodule

### tb/diff_drive_odometry_tb.sv
`timescale 1ns / 1ps

module diff_drive_odometry_tb;
	import ddo_pkg::*;

	localparam longint POS_HI = 64'sd140737488355327;
	localparam longint POS_LO = -64'sd140737488355328;
	localparam longint I32_HI = 64'sd2147483647;
	localparam longint I32_LO = -64'sd2147483648;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam int SETTLE_CYCLES = 200;

	typedef struct {
		logic signed [31:0] vr, vl, dr, dl, lt, rt;
		bit fixed;
		logic signed [31:0] lin, ang;
	} odo_row_t;

	typedef struct {
		logic signed [47:0] px, py;
		logic signed [31:0] hd, qz, qw, lin, ang, lt, rt;
	} pose_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [20:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [31:0] right_velocity, left_velocity, right_displacement, left_displacement;
	logic signed [31:0] left_ticks, right_ticks;
	logic out_valid, out_ready;
	logic signed [47:0] pos_x, pos_y;
	logic signed [31:0] heading, quat_z, quat_w, linear_velocity, angular_velocity;
	logic signed [31:0] left_ticks_out, right_ticks_out;

	// row flags travel with the payload so they are sampled at the same edge
	logic row_fixed;
	logic signed [31:0] row_lin, row_ang;

	logic [20:0] diam_m, base_m;
	longint px_m, py_m;
	logic [31:0] hd_m;
	pose_t pose_q[$];
	int errors;
	int burst_left;

	diff_drive_odometry dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("** diff_drive_odometry: FAILED **");
		$finish;
	end

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint round_up_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint div_away(longint n, longint unsigned d);
		longint unsigned mag, q;
		mag = n < 0 ? longint'(0) - n : n;
		q = (mag + d / 2) / d;
		return n < 0 ? -longint'(q) : longint'(q);
	endfunction

	task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
		longint x, y, z, xs, ys;
		logic [31:0] turned;
		x = 652032874;
		y = 0;
		z = longint'(signed'(ang));
		if (z > ONE_Q30 || z < -ONE_Q30) begin
			x = -652032874;
			turned = ang + 32'h8000_0000;
			z = longint'(signed'(turned));
		end
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(atan_lut(5'(i)));
			end else begin
				x += ys; y -= xs; z += longint'(atan_lut(5'(i)));
			end
		end
		c = clip(x, -ONE_Q30, ONE_Q30);
		s = clip(y, -ONE_Q30, ONE_Q30);
	endtask

	task automatic advance_pose(input odo_row_t r, output pose_t p);
		longint d, stp, dth, c, s, qw, qz, half;
		longint unsigned b2, mag, bmag;
		logic [31:0] dbam;
		d = longint'(diam_m);
		b2 = 2 * longint'(base_m != 0 ? base_m : 21'd1);
		p.lin = 32'(clip(round_up_shift(d * (longint'(r.vr) + longint'(r.vl)), FRAC_BITS + 2),
			I32_LO, I32_HI));
		p.ang = 32'(clip(div_away(d * (longint'(r.vr) - longint'(r.vl)), b2), I32_LO, I32_HI));
		stp = clip(round_up_shift(d * (longint'(r.dr) + longint'(r.dl)), FRAC_BITS + 2),
			I32_LO, I32_HI);
		dth = clip(div_away(d * (longint'(r.dr) - longint'(r.dl)), b2), I32_LO, I32_HI);
		rotate(hd_m, c, s);
		px_m = clip(px_m + round_up_shift(stp * c, 30), POS_LO, POS_HI);
		py_m = clip(py_m + round_up_shift(stp * s, 30), POS_LO, POS_HI);
		mag = dth < 0 ? longint'(0) - dth : dth;
		bmag = (mag * longint'(RAD_TO_BAM) + (longint'(1) << (FRAC_BITS + 1))) >> (FRAC_BITS + 2);
		dbam = bmag[31:0];
		if (dth < 0)
			dbam = 32'd0 - dbam;
		hd_m += dbam;
		half = longint'(signed'(hd_m)) >>> 1;
		rotate(half[31:0], qw, qz);
		p.px = px_m[47:0];
		p.py = py_m[47:0];
		p.hd = hd_m;
		p.qz = qz[31:0];
		p.qw = qw[31:0];
		p.lt = r.lt;
		p.rt = r.rt;
		if (r.fixed) begin
			p.lin = r.lin;
			p.ang = r.ang;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diam_m <= DIAM_RESET;
			base_m <= BASE_RESET;
			px_m = 0;
			py_m = 0;
			hd_m = 0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DIAMETER)
				diam_m <= cfg_data;
			else if (cfg_index == REG_BASE)
				base_m <= cfg_data;
		end
	end

	always @(posedge clk) begin
		odo_row_t r;
		pose_t p, e;
		if (arst_n && in_valid && in_ready) begin
			r.vr = right_velocity; r.vl = left_velocity;
			r.dr = right_displacement; r.dl = left_displacement;
			r.lt = left_ticks; r.rt = right_ticks;
			r.fixed = row_fixed; r.lin = row_lin; r.ang = row_ang;
			advance_pose(r, p);
			pose_q.push_back(p);
		end
		if (arst_n && out_valid && out_ready) begin
			if (pose_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transaction", $time);
			end else begin
				e = pose_q.pop_front();
				if (pos_x !== e.px) begin
					errors++; $display("%0t: pos_x exp %0d got %0d", $time, e.px, pos_x);
				end
				if (pos_y !== e.py) begin
					errors++; $display("%0t: pos_y exp %0d got %0d", $time, e.py, pos_y);
				end
				if (heading !== e.hd) begin
					errors++; $display("%0t: heading exp %0d got %0d", $time, e.hd, heading);
				end
				if (quat_z !== e.qz) begin
					errors++; $display("%0t: quat_z exp %0d got %0d", $time, e.qz, quat_z);
				end
				if (quat_w !== e.qw) begin
					errors++; $display("%0t: quat_w exp %0d got %0d", $time, e.qw, quat_w);
				end
				if (linear_velocity !== e.lin) begin
					errors++;
					$display("%0t: linear_velocity exp %0d got %0d", $time, e.lin, linear_velocity);
				end
				if (angular_velocity !== e.ang) begin
					errors++;
					$display("%0t: angular_velocity exp %0d got %0d", $time, e.ang,
						angular_velocity);
				end
				if (left_ticks_out !== e.lt) begin
					errors++;
					$display("%0t: left_ticks_out exp %0d got %0d", $time, e.lt, left_ticks_out);
				end
				if (right_ticks_out !== e.rt) begin
					errors++;
					$display("%0t: right_ticks_out exp %0d got %0d", $time, e.rt, right_ticks_out);
				end
			end
		end
	end

	// receiver: long ready stretches, random stalls, and occasional long stalls
	initial begin
		int mode, len;
		out_ready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(5, 400);
			repeat (len) begin
				@(posedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 40) == 0);
				endcase
			end
		end
	end

	function automatic logic signed [31:0] pick32();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			3: return $signed($urandom_range(0, 1 << 14)) - (1 << 13);
			4: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return 32'sd0;
		endcase
	endfunction

	function automatic logic [20:0] pick_reg();
		case ($urandom_range(0, 4))
			0: return 21'd0;
			1: return 21'd1 << 20;
			2: return 21'($urandom_range(1, 1 << 20));
			3: return 21'($urandom_range(1, 70000));
			default: return 21'($urandom);
		endcase
	endfunction

	task automatic drain();
		while (pose_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [20:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_row(input odo_row_t r);
		int gap;
		right_velocity <= r.vr; left_velocity <= r.vl;
		right_displacement <= r.dr; left_displacement <= r.dl;
		left_ticks <= r.lt; right_ticks <= r.rt;
		row_fixed <= r.fixed; row_lin <= r.lin; row_ang <= r.ang;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 150) : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_plain(input logic signed [31:0] vr, vl, dr, dl, lt, rt);
		odo_row_t r;
		r = '{vr, vl, dr, dl, lt, rt, 1'b0, 32'sd0, 32'sd0};
		send_row(r);
	endtask

	odo_row_t plain_rows[] = '{
		'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 0, 0},
		'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh80000000, 1'b0, 0, 0},
		'{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh7fffffff, 1'b0, 0, 0},
		'{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, -1, 1, 1'b0, 0, 0},
		'{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1, -1, 1'b0, 0, 0},
		'{32'sd65536, 32'sd65536, 32'sd655360, 32'sd655360, 7, 9, 1'b0, 0, 0},
		'{32'sd65536, -32'sd65536, 32'sd102943, -32'sd102943, 3, 4, 1'b0, 0, 0},
		'{-32'sd1, 32'sd0, -32'sd1, 32'sd0, 32'sh55555555, 32'shaaaaaaaa, 1'b0, 0, 0},
		'{32'sd1, 32'sd1, 32'sd1, 32'sd0, 0, 0, 1'b0, 0, 0}
	};

	// zero diameter: every speed is zero
	odo_row_t zero_rows[] = '{
		'{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 5, 6, 1'b1, 0, 0},
		'{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, -5, -6, 1'b1, 0, 0},
		'{32'sd12345, -32'sd999, 32'sd4242, 32'sd1, 0, 0, 1'b1, 0, 0}
	};

	// largest diameter, zero base: speeds that overflow clip at the 32-bit limits
	odo_row_t sat_rows[] = '{
		'{32'sh7fffffff, 32'sh7fffffff, 32'sd65536, 32'sd0, 1, 2, 1'b1,
			32'sh7fffffff, 32'sd0},
		'{32'sh80000000, 32'sh80000000, 32'sd0, 32'sd65536, 3, 4, 1'b1,
			32'sh80000000, 32'sd0},
		'{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0, 1'b1,
			-32'sd4, 32'sh7fffffff},
		'{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 1'b1,
			-32'sd4, 32'sh80000000}
	};

	initial begin
		arst_n = 1'b0;
		cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
		in_valid <= 1'b0;
		right_velocity <= '0; left_velocity <= '0;
		right_displacement <= '0; left_displacement <= '0;
		left_ticks <= '0; right_ticks <= '0;
		row_fixed <= 1'b0; row_lin <= '0; row_ang <= '0;
		errors = 0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plain_rows[i]) send_row(plain_rows[i]);
		in_valid <= 1'b0;
		drain();
		write_reg(REG_DIAMETER, 21'd0);
		foreach (zero_rows[i]) send_row(zero_rows[i]);
		in_valid <= 1'b0;
		drain();
		write_reg(REG_DIAMETER, 21'd1 << 20);
		write_reg(REG_BASE, 21'd0);
		write_reg(CFG_IDX_W'(2), 21'd5);
		write_reg(CFG_IDX_W'(3), 21'h1fffff);
		foreach (sat_rows[i]) send_row(sat_rows[i]);
		// heading wraps after several full-range turns
		repeat (6) send_plain(0, 0, 32'sh7fffffff, 32'sh80000000, 0, 0);
		in_valid <= 1'b0;
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_DIAMETER, DIAM_RESET); write_reg(REG_BASE, BASE_RESET); end
				1: begin write_reg(REG_DIAMETER, 21'd1); write_reg(REG_BASE, 21'd1 << 20); end
				2: begin write_reg(REG_DIAMETER, 21'd1 << 20); write_reg(REG_BASE, 21'd1); end
				default: begin
					write_reg(CFG_IDX_W'($urandom_range(0, 3)), pick_reg());
					write_reg(REG_DIAMETER, pick_reg());
					write_reg(REG_BASE, pick_reg());
				end
			endcase
			for (int n = 0; n < 205; n++) begin
				if (n == 100 && ph % 2 == 0) begin
					in_valid <= 1'b0;
					while (pose_q.size() != 0)
						@(posedge clk);
				end
				if ($urandom_range(0, 4) == 0)
					send_plain(pick32(), pick32(), pick32(), pick32(), $urandom, $urandom);
				else
					send_plain($signed($urandom_range(0, 1 << 22)) - (1 << 21),
						$signed($urandom_range(0, 1 << 22)) - (1 << 21),
						$signed($urandom_range(0, 1 << 18)) - (1 << 17),
						$signed($urandom_range(0, 1 << 18)) - (1 << 17),
						$urandom, $urandom);
			end
			in_valid <= 1'b0;
			drain();
		end

		if (errors == 0)
			$display("** diff_drive_odometry: PASSED **");
		else
			$display("** diff_drive_odometry: FAILED **");
		$finish;
	end

endmodule
